FILE: rtl/core/bls_pkg.sv
// ============================================================================
// bls_pkg
// Types, constants and helpers for the bit angle modulation LED cube scanner.
// ============================================================================
package bls_pkg;

    localparam int LAYERS_DEF     = 8;
    localparam int ROWS           = 8;
    localparam int COLOURS        = 3;
    localparam int PLANES         = 4;
    localparam int WORD_W         = COLOURS * PLANES * 8;
    localparam int BYTES_PER_TICK = COLOURS * ROWS;

    // modulation counter values at which the shown bit plane advances
    localparam logic [6:0] MOD_STEP0  = 7'd8;
    localparam logic [6:0] MOD_STEP1  = 7'd24;
    localparam logic [6:0] MOD_STEP2  = 7'd56;
    localparam logic [6:0] MOD_PERIOD = 7'd120;
    localparam logic [1:0] PLANE_LAST = 2'd3;
    localparam logic [7:0] COORD_MAX  = 8'd7;
    localparam logic [7:0] VALUE_MAX  = 8'd15;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SET_RD,
        ST_SET_WR,
        ST_TICK
    } t_state;

    typedef struct packed {
        logic       cmd;
        logic [7:0] led_level;
        logic [7:0] led_row;
        logic [7:0] led_column;
        logic [7:0] red_value;
        logic [7:0] green_value;
        logic [7:0] blue_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] shift_byte;
        logic [2:0] anode_select;
        logic [1:0] plane_bit;
        logic       last;
    } t_out_item;

    // one row of one layer: byte (colour*4 + plane) holds that bit plane
    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic [2:0] col;
        logic [3:0] red;
        logic [3:0] green;
        logic [3:0] blue;
    } t_led;

    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        t_led       led;
        logic [1:0] out_colour;
        logic [1:0] out_plane;
        logic [2:0] out_anode;
        logic       out_last;
    } t_ctrl;

    function automatic logic [3:0] bls_sat4(logic [7:0] v);
        return (v > VALUE_MAX) ? 4'(VALUE_MAX) : v[3:0];
    endfunction

    function automatic logic [2:0] bls_sat3(logic [7:0] v);
        return (v > COORD_MAX) ? 3'(COORD_MAX) : v[2:0];
    endfunction

    // replace the column bit in all twelve planes of one row
    function automatic t_word bls_merge(t_word old, t_led led);
        t_word       w;
        logic [11:0] bits;
        w    = old;
        bits = {led.blue, led.green, led.red};
        for (int i = 0; i < COLOURS * PLANES; i++) begin
            w[i * 8 + int'(led.col)] = bits[i];
        end
        return w;
    endfunction

endpackage

FILE: rtl/core/bls_ram.sv
// ============================================================================
// bls_ram
// Generic simple dual port RAM, one write and one registered read port.
// ============================================================================
module bls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        // hold read data between reads
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/bls_ctrl.sv
// ============================================================================
// bls_ctrl
// Sequencer: input handshake, modulation counter, set read-modify-write
// steps and the 24-byte read sweep of a refresh tick.
// ============================================================================
module bls_ctrl #(
    parameter int LAYERS = bls_pkg::LAYERS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  bls_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output bls_pkg::t_ctrl                  o_ctrl,
    output logic [$clog2(LAYERS*8)-1:0]     o_addr
);

    import bls_pkg::*;

    localparam int LW = $clog2(LAYERS);

    t_state       r_state, n_state;
    logic [6:0]   r_cnt, n_cnt;
    logic [1:0]   r_plane, n_plane;
    logic [LW-1:0] r_layer, n_layer;
    logic [1:0]   r_show_plane, n_show_plane;
    logic [LW-1:0] r_show_layer, n_show_layer;
    logic [4:0]   r_k, n_k;
    logic         r_ovalid, n_ovalid;
    logic [4:0]   r_ok, n_ok;
    logic [1:0]   r_out_plane, n_out_plane;
    logic [2:0]   r_out_anode, n_out_anode;
    logic [LW-1:0] r_set_level, n_set_level;
    logic [2:0]   r_set_row, n_set_row;
    t_led         r_led, n_led;

    logic [1:0]   plane_eff;
    logic [6:0]   cnt_inc;
    logic [LW-1:0] layer_eff;
    logic         rd_en, wr_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_plane  <= '0;
            r_layer  <= '0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_plane  <= n_plane;
            r_layer  <= n_layer;
            r_k      <= n_k;
            r_ovalid <= n_ovalid;
        end
        r_show_plane <= n_show_plane;
        r_show_layer <= n_show_layer;
        r_ok         <= n_ok;
        r_out_plane  <= n_out_plane;
        r_out_anode  <= n_out_anode;
        r_set_level  <= n_set_level;
        r_set_row    <= n_set_row;
        r_led        <= n_led;
    end

    always_comb begin
        plane_eff = r_plane;
        if (r_cnt == MOD_STEP0 || r_cnt == MOD_STEP1 || r_cnt == MOD_STEP2) begin
            plane_eff = r_plane + 2'd1;
        end
        cnt_inc   = r_cnt + 7'd1;
        layer_eff = ({1'b0, r_layer} >= (LW+1)'(LAYERS)) ? '0 : r_layer;
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_plane      = r_plane;
        n_layer      = r_layer;
        n_show_plane = r_show_plane;
        n_show_layer = r_show_layer;
        n_k          = r_k;
        n_ovalid     = r_ovalid;
        n_ok         = r_ok;
        n_out_plane  = r_out_plane;
        n_out_anode  = r_out_anode;
        n_set_level  = r_set_level;
        n_set_row    = r_set_row;
        n_led        = r_led;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        o_addr       = {r_set_level, r_set_row};
        o_in_ready   = (r_state == ST_IDLE);

        // drop the held byte once taken
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.cmd) begin
                        n_show_plane = plane_eff;
                        n_show_layer = layer_eff;
                        if (plane_eff == PLANE_LAST && cnt_inc == MOD_PERIOD) begin
                            n_cnt   = '0;
                            n_plane = '0;
                        end else begin
                            n_cnt   = cnt_inc;
                            n_plane = plane_eff;
                        end
                        n_layer = (layer_eff == LW'(LAYERS - 1)) ? '0 : layer_eff + LW'(1);
                        n_k     = '0;
                        n_state = ST_TICK;
                    end else begin
                        n_set_level = (i_in_data.led_level > 8'(LAYERS - 1)) ?
                                      LW'(LAYERS - 1) : i_in_data.led_level[LW-1:0];
                        n_set_row   = bls_sat3(i_in_data.led_row);
                        n_led.col   = bls_sat3(i_in_data.led_column);
                        n_led.red   = bls_sat4(i_in_data.red_value);
                        n_led.green = bls_sat4(i_in_data.green_value);
                        n_led.blue  = bls_sat4(i_in_data.blue_value);
                        n_state     = ST_SET_RD;
                    end
                end
            end
            ST_SET_RD: begin
                // the read port also feeds the output; wait until it is free
                if (!r_ovalid) begin
                    rd_en   = 1'b1;
                    n_state = ST_SET_WR;
                end
            end
            ST_SET_WR: begin
                wr_en   = 1'b1;
                n_state = ST_IDLE;
            end
            ST_TICK: begin
                o_addr = {r_show_layer, r_k[2:0]};
                if (!r_ovalid || i_out_ready) begin
                    rd_en       = 1'b1;
                    n_ovalid    = 1'b1;
                    n_ok        = r_k;
                    // hold plane and anode with the byte, a new tick may start under it
                    n_out_plane = r_show_plane;
                    n_out_anode = 3'(r_show_layer);
                    n_k         = r_k + 5'd1;
                    if (r_k == 5'(BYTES_PER_TICK - 1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid       = r_ovalid;
    assign o_ctrl.rd_en      = rd_en;
    assign o_ctrl.wr_en      = wr_en;
    assign o_ctrl.led        = r_led;
    assign o_ctrl.out_colour = r_ok[4:3];
    assign o_ctrl.out_plane  = r_out_plane;
    assign o_ctrl.out_anode  = r_out_anode;
    assign o_ctrl.out_last   = (r_ok == 5'(BYTES_PER_TICK - 1));

    a_out_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == ST_TICK)
        else $error("output byte appeared outside a tick sweep");

    a_write_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !r_ovalid)
        else $error("plane write while an output byte is held");

    a_held_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_out_ready) |=> $stable(r_ok))
        else $error("held byte index changed under stall");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < MOD_PERIOD)
        else $error("modulation counter out of range");

    a_plane_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= MOD_STEP0) |-> (r_plane == 2'd0))
        else $error("bit plane not zero at start of period");

endmodule

FILE: rtl/core/bam_led_cube_scanner_top.sv
// ============================================================================
// bam_led_cube_scanner_top
// 4-bit bit angle modulation scanner for an RGB LED cube with layer muxing.
// ============================================================================
//
//   port group   dir  handshake               payload
//   input item   in   i_in_valid/o_in_ready   i_in_data  (t_in_item)
//   result byte  out  o_out_valid/i_out_ready o_out_data (t_out_item)
//
// A set command runs accept, row read, row write (read-modify-write
// of one 96-bit plane row). A tick runs accept, then one plane RAM read per
// byte over its 24 bytes, as there is a single read port.
// Reset clears control state and the per-row valid bits; no clearing pass is
// needed, a row never written reads as zero. An output stall holds the read
// port and the sweep; a set waits until the last byte of a tick is taken.
// ============================================================================
module bam_led_cube_scanner_top #(
    parameter int LAYERS = bls_pkg::LAYERS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bls_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bls_pkg::t_out_item o_out_data
);

    import bls_pkg::*;

    localparam int DEPTH = LAYERS * ROWS;
    localparam int AW    = $clog2(DEPTH);

    t_ctrl           ctrl;
    logic [AW-1:0]   addr;
    t_word           rdata;
    t_word           row_eff;
    logic [DEPTH-1:0] r_vld;
    logic            r_rd_vld;
    logic [3:0]      byte_sel;

    bls_ctrl #(
        .LAYERS (LAYERS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctrl      (ctrl),
        .o_addr      (addr)
    );

    bls_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_plane_ram (
        .i_clk   (i_clk),
        .i_we    (ctrl.wr_en),
        .i_waddr (addr),
        .i_wdata (bls_merge(row_eff, ctrl.led)),
        .i_re    (ctrl.rd_en),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    // one valid bit per row; an unwritten row reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (ctrl.wr_en) begin
                r_vld[addr] <= 1'b1;
            end
            if (ctrl.rd_en) begin
                r_rd_vld <= r_vld[addr];
            end
        end
    end

    assign row_eff  = r_rd_vld ? rdata : '0;
    assign byte_sel = {ctrl.out_colour, ctrl.out_plane};

    assign o_out_data.shift_byte   = row_eff[byte_sel * 8 +: 8];
    assign o_out_data.anode_select = ctrl.out_anode;
    assign o_out_data.plane_bit    = ctrl.out_plane;
    assign o_out_data.last         = ctrl.out_last;

endmodule
